/* rtl/bhp_pkg.sv */
// shared constants for the beam and histogram pruning cutoff block
package bhp_pkg;
  localparam int MAX_TOKENS_DEF    = 1024;
  localparam int STATE_ID_BITS_DEF = 24;

  localparam logic signed [31:0] COST_INF = 32'sh7FFF_FFFF;

  localparam logic [1:0] CFG_BEAM_WIDTH = 2'd0;
  localparam logic [1:0] CFG_BEAM_DELTA = 2'd1;
  localparam logic [1:0] CFG_MAX_ACTIVE = 2'd2;
  localparam logic [1:0] CFG_MIN_ACTIVE = 2'd3;

  localparam logic [1:0] LIM_BEAM = 2'd0;
  localparam logic [1:0] LIM_MAX  = 2'd1;
  localparam logic [1:0] LIM_MIN  = 2'd2;
endpackage

/* rtl/beam_histogram_prune_cutoff_core.sv */
// beam and histogram pruning cutoff: cost store, rank search and cutoff logic
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | token_cost, state_id, last_token
//  out     | output    | out_valid / out_stall | cutoff, next_beam, min_cost ..
//  cfg     | input     | cfg_we                | cfg_index, cfg_wdata
//
// non-last tokens are taken one per cycle while idle. a last token starts the rank
// search, which walks the cost store through its single read port, for at
// most two ranks per frame, followed by the cutoff math. reset is synchronous
// and clears control and frame state; the store needs no clearing. in_stall is
// high for the whole search and while a finished result waits behind a stalled
// out beat.
module beam_histogram_prune_cutoff_core #(
  parameter int MAX_TOKENS    = bhp_pkg::MAX_TOKENS_DEF,
  parameter int STATE_ID_BITS = bhp_pkg::STATE_ID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [31:0]        in_token_cost,
  input  logic [STATE_ID_BITS-1:0]  in_state_id,
  input  logic                      in_last_token,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        out_cutoff,
  output logic signed [31:0]        out_next_beam,
  output logic signed [31:0]        out_min_cost,
  output logic [STATE_ID_BITS-1:0]  out_best_state,
  output logic [10:0]               out_token_count,
  output logic [1:0]                out_limit_used,
  output logic                      out_overflow,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [23:0]               cfg_wdata
);
  import bhp_pkg::*;

  localparam int AW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int CW = $clog2(MAX_TOKENS + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MAXC = 4'd1;
  localparam logic [3:0] ST_RDI  = 4'd2;
  localparam logic [3:0] ST_LDV  = 4'd3;
  localparam logic [3:0] ST_SCAN = 4'd4;
  localparam logic [3:0] ST_CHK  = 4'd5;
  localparam logic [3:0] ST_DEC  = 4'd6;
  localparam logic [3:0] ST_MINC = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;
  localparam logic [3:0] ST_ABM  = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  logic signed [31:0] mem [MAX_TOKENS];
  logic signed [31:0] rd_data_r;
  logic [AW-1:0]      rd_addr;

  logic [3:0]               state_r;
  logic [23:0]              beam_width_r, beam_delta_r;
  logic [10:0]              keep_max_r;
  logic [9:0]               keep_min_r;
  logic [CW-1:0]            count_r;
  logic signed [31:0]       best_r;
  logic [STATE_ID_BITS-1:0] best_state_r;
  logic                     drop_r;

  logic [CW-1:0]      i_r, j_r, less_r, eq_r;
  logic               pend_r, phase_min_r;
  logic [10:0]        sel_k_r;
  logic signed [31:0] v_r, beam_cut_r, max_cut_r, min_cut_r, cut_r;
  logic signed [34:0] diff_r;
  logic [1:0]         limit_r;

  logic signed [34:0] beam_sum, abeam_sum;
  logic [CW:0]        lt_eq_sum;
  logic               found;
  logic               load_out;

  assign in_stall  = (state_r != ST_IDLE);
  assign beam_sum  = 35'(best_r) + 35'(signed'({1'b0, beam_width_r}));
  assign abeam_sum = diff_r + 35'(signed'({1'b0, beam_delta_r}));
  assign lt_eq_sum = (CW+1)'(less_r) + (CW+1)'(eq_r);
  assign found     = (32'(less_r) <= 32'(sel_k_r)) && (32'(sel_k_r) < 32'(lt_eq_sum));
  assign load_out  = (state_r == ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    if (state_r == ST_RDI) begin
      rd_addr = i_r[AW-1:0];
    end else begin
      rd_addr = j_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (state_r == ST_IDLE && in_valid && 32'(count_r) < 32'(MAX_TOKENS)) begin
      mem[count_r[AW-1:0]] <= in_token_cost;
    end
  end

  // compare pipeline counts from the registered read data, so it trails the read address
  always_ff @(posedge clk) begin
    if (pend_r) begin
      if (rd_data_r < v_r) begin
        less_r <= less_r + 1'b1;
      end else if (rd_data_r == v_r) begin
        eq_r <= eq_r + 1'b1;
      end
    end
    if (state_r == ST_LDV) begin
      less_r <= '0;
      eq_r   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      beam_width_r <= 24'd4096;
      beam_delta_r <= 24'd128;
      keep_max_r   <= 11'd1024;
      keep_min_r   <= 10'd20;
      count_r      <= '0;
      best_r       <= COST_INF;
      best_state_r <= '0;
      drop_r       <= 1'b0;
      pend_r       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BEAM_WIDTH: beam_width_r <= cfg_wdata;
          CFG_BEAM_DELTA: beam_delta_r <= cfg_wdata;
          CFG_MAX_ACTIVE: keep_max_r   <= cfg_wdata[10:0];
          CFG_MIN_ACTIVE: keep_min_r   <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (32'(count_r) < 32'(MAX_TOKENS)) begin
              count_r <= count_r + 1'b1;
              if (in_token_cost < best_r) begin
                best_r       <= in_token_cost;
                best_state_r <= in_state_id;
              end
            end else begin
              drop_r <= 1'b1;
            end
            if (in_last_token) begin
              state_r <= ST_MAXC;
            end
          end
        end
        ST_MAXC: begin
          beam_cut_r <= (beam_sum > 35'(COST_INF)) ? COST_INF : beam_sum[31:0];
          if (32'(count_r) > 32'(keep_max_r)) begin
            sel_k_r     <= keep_max_r;
            phase_min_r <= 1'b0;
            i_r         <= '0;
            state_r     <= ST_RDI;
          end else begin
            max_cut_r <= COST_INF;
            state_r   <= ST_DEC;
          end
        end
        ST_RDI: state_r <= ST_LDV;
        ST_LDV: begin
          v_r     <= rd_data_r;
          j_r     <= '0;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (j_r < count_r) begin
            j_r    <= j_r + 1'b1;
            pend_r <= 1'b1;
          end else begin
            pend_r  <= 1'b0;
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (found || (i_r + 1'b1) == count_r) begin
            if (phase_min_r) begin
              min_cut_r <= found ? v_r : COST_INF;
              state_r   <= ST_FIN;
            end else begin
              max_cut_r <= found ? v_r : COST_INF;
              state_r   <= ST_DEC;
            end
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= ST_RDI;
          end
        end
        ST_DEC: begin
          if (max_cut_r < beam_cut_r) begin
            cut_r   <= max_cut_r;
            limit_r <= LIM_MAX;
            state_r <= ST_ABM;
          end else begin
            state_r <= ST_MINC;
          end
        end
        ST_MINC: begin
          if (32'(count_r) > 32'(keep_min_r)) begin
            if (keep_min_r == '0) begin
              min_cut_r <= best_r;
              state_r   <= ST_FIN;
            end else begin
              sel_k_r     <= {1'b0, keep_min_r};
              phase_min_r <= 1'b1;
              i_r         <= '0;
              state_r     <= ST_RDI;
            end
          end else begin
            min_cut_r <= COST_INF;
            state_r   <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (min_cut_r > beam_cut_r) begin
            cut_r   <= min_cut_r;
            limit_r <= LIM_MIN;
          end else begin
            cut_r   <= beam_cut_r;
            limit_r <= LIM_BEAM;
          end
          state_r <= ST_ABM;
        end
        ST_ABM: begin
          diff_r  <= 35'(cut_r) - 35'(best_r);
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (load_out) begin
            out_valid         <= 1'b1;
            out_cutoff        <= cut_r;
            if (limit_r == LIM_BEAM) begin
              out_next_beam <= 32'(signed'({1'b0, beam_width_r}));
            end else begin
              out_next_beam <= (abeam_sum > 35'(COST_INF)) ? COST_INF
                                                           : abeam_sum[31:0];
            end
            out_min_cost    <= best_r;
            out_best_state  <= best_state_r;
            out_token_count <= 11'(count_r);
            out_limit_used  <= limit_r;
            out_overflow    <= drop_r;
            count_r         <= '0;
            best_r          <= COST_INF;
            best_state_r    <= '0;
            drop_r          <= 1'b0;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

/* dv/testbench.sv */
// testbench for the beam and histogram pruning cutoff core
`timescale 1ns / 1ps

typedef struct {
  logic signed [31:0] cutoff;
  logic signed [31:0] abeam;
  logic signed [31:0] best;
  logic [23:0]        best_state;
  logic [10:0]        count;
  logic [1:0]         limit;
  logic               overflow;
} frame_result_t;

class cutoff_scoreboard;
  logic signed [31:0] cost_mem [bhp_pkg::MAX_TOKENS_DEF];
  int unsigned        n_stored;
  longint             frame_best;
  logic [23:0]        best_sid;
  bit                 dropped;
  int unsigned        beam_width, beam_delta, keep_cap, keep_floor;
  frame_result_t      pending_frames[$];
  int                 errors;

  function new();
    errors = 0;
    beam_width = 4096;
    beam_delta = 128;
    keep_cap = 1024;
    keep_floor = 20;
    clear_frame();
  endfunction

  function void clear_frame();
    n_stored = 0;
    frame_best = bhp_pkg::COST_INF;
    best_sid = '0;
    dropped = 0;
  endfunction

  // k-th smallest of the stored costs, zero based
  function longint kth_cost(int unsigned k);
    int unsigned less, equal;
    for (int i = 0; i < n_stored; i++) begin
      less = 0;
      equal = 0;
      for (int j = 0; j < n_stored; j++) begin
        if (cost_mem[j] < cost_mem[i]) less++;
        else if (cost_mem[j] == cost_mem[i]) equal++;
      end
      if (less <= k && k < less + equal) return longint'(cost_mem[i]);
    end
    return bhp_pkg::COST_INF;
  endfunction

  function longint sat(longint v);
    return (v > bhp_pkg::COST_INF) ? longint'(bhp_pkg::COST_INF) : v;
  endfunction

  function void note_token(logic signed [31:0] cost, logic [23:0] sid, bit last);
    frame_result_t r;
    longint beam_cut, max_cut, min_cut, cut, ab;
    logic [1:0] lim;
    if (n_stored < bhp_pkg::MAX_TOKENS_DEF) begin
      cost_mem[n_stored] = cost;
      n_stored++;
      if (longint'(cost) < frame_best) begin
        frame_best = cost;
        best_sid = sid;
      end
    end else begin
      dropped = 1;
    end
    if (!last) return;
    beam_cut = sat(frame_best + beam_width);
    max_cut = bhp_pkg::COST_INF;
    min_cut = bhp_pkg::COST_INF;
    if (n_stored > keep_cap) max_cut = kth_cost(keep_cap);
    if (max_cut < beam_cut) begin
      lim = bhp_pkg::LIM_MAX;
      cut = max_cut;
      ab = sat(max_cut - frame_best + beam_delta);
    end else begin
      if (n_stored > keep_floor)
        min_cut = (keep_floor == 0) ? frame_best : kth_cost(keep_floor);
      if (min_cut > beam_cut) begin
        lim = bhp_pkg::LIM_MIN;
        cut = min_cut;
        ab = sat(min_cut - frame_best + beam_delta);
      end else begin
        lim = bhp_pkg::LIM_BEAM;
        cut = beam_cut;
        ab = beam_width;
      end
    end
    r.cutoff = cut[31:0];
    r.abeam = ab[31:0];
    r.best = frame_best[31:0];
    r.best_state = best_sid;
    r.count = n_stored[10:0];
    r.limit = lim;
    r.overflow = dropped;
    pending_frames.insert(pending_frames.size(), r);
    clear_frame();
  endfunction

  function void check_frame(frame_result_t got);
    frame_result_t exp_r;
    if (pending_frames.size() == 0) begin
      $display("%0t: unexpected result beat, cutoff %h", $time, got.cutoff);
      errors++;
      return;
    end
    exp_r = pending_frames.pop_front();
    if (got.cutoff !== exp_r.cutoff) begin
      $display("%0t: cutoff exp %h got %h", $time, exp_r.cutoff, got.cutoff);
      errors++;
    end
    if (got.abeam !== exp_r.abeam) begin
      $display("%0t: next beam exp %h got %h", $time, exp_r.abeam, got.abeam);
      errors++;
    end
    if (got.best !== exp_r.best) begin
      $display("%0t: min cost exp %h got %h", $time, exp_r.best, got.best);
      errors++;
    end
    if (got.best_state !== exp_r.best_state) begin
      $display("%0t: best_state exp %h got %h", $time, exp_r.best_state,
               got.best_state);
      errors++;
    end
    if (got.count !== exp_r.count) begin
      $display("%0t: token_count exp %0d got %0d", $time, exp_r.count, got.count);
      errors++;
    end
    if (got.limit !== exp_r.limit) begin
      $display("%0t: limit_used exp %0d got %0d", $time, exp_r.limit, got.limit);
      errors++;
    end
    if (got.overflow !== exp_r.overflow) begin
      $display("%0t: overflow exp %0d got %0d", $time, exp_r.overflow, got.overflow);
      errors++;
    end
  endfunction
endclass

module testbench;
  import bhp_pkg::*;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [31:0] in_token_cost = '0;
  logic [23:0]        in_state_id = '0;
  logic               in_last_token = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] out_cutoff, out_next_beam, out_min_cost;
  logic [23:0]        out_best_state;
  logic [10:0]        out_token_count;
  logic [1:0]         out_limit_used;
  logic               out_overflow;
  logic               cfg_we = 0;
  logic [1:0]         cfg_index = CFG_BEAM_WIDTH;
  logic [23:0]        cfg_wdata = '0;

  cutoff_scoreboard sb = new();
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  hold_cycles = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  longint cycle_count = 0;

  beam_histogram_prune_cutoff_core DUT (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1;
      hold_cycles <= 3000;
      hold_done <= 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(negedge clk) begin
    frame_result_t r;
    if (rst_n && out_valid && !out_stall) begin
      r.cutoff = out_cutoff;
      r.abeam = out_next_beam;
      r.best = out_min_cost;
      r.best_state = out_best_state;
      r.count = out_token_count;
      r.limit = out_limit_used;
      r.overflow = out_overflow;
      sb.check_frame(r);
    end
  end

  task automatic send_token(logic signed [31:0] cost, logic [23:0] sid, bit last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_token_cost <= cost;
    in_state_id <= sid;
    in_last_token <= last;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sb.note_token(cost, sid, last);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned bw, int unsigned bd, int unsigned mx,
                          int unsigned mn);
    wait_idle();
    cfg_we <= 1;
    cfg_index <= CFG_BEAM_WIDTH;
    cfg_wdata <= 24'(bw);
    @(posedge clk);
    cfg_index <= CFG_BEAM_DELTA;
    cfg_wdata <= 24'(bd);
    @(posedge clk);
    cfg_index <= CFG_MAX_ACTIVE;
    cfg_wdata <= 24'(mx);
    @(posedge clk);
    cfg_index <= CFG_MIN_ACTIVE;
    cfg_wdata <= 24'(mn);
    @(posedge clk);
    cfg_we <= 0;
    sb.beam_width = bw;
    sb.beam_delta = bd;
    sb.keep_cap = mx;
    sb.keep_floor = mn;
  endtask

  function automatic logic signed [31:0] pick_cost();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return COST_INF;
    if (sel < 8) return 32'sh8000_0000;
    if (sel < 18) return $urandom;
    if (sel < 30) return $urandom_range(0, 15) * 64;
    return $signed($urandom_range(0, 8000)) - 4000;
  endfunction

  task automatic random_frame(int unsigned n);
    for (int i = 0; i < n; i++)
      send_token(pick_cost(), 24'($urandom_range(0, 24'hFFFFFF)), i == n - 1);
  endtask

  task automatic random_regs(int unsigned n);
    int unsigned bw, bd, mx, mn;
    case ($urandom_range(0, 3))
      0: bw = 0;
      1: bw = 24'hFFFFFF;
      2: bw = $urandom_range(0, 24'hFFFFFF);
      default: bw = $urandom_range(0, 6000);
    endcase
    bd = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : $urandom_range(0, 24'hFFFFFF);
    mx = ($urandom_range(0, 5) == 0) ? 1024 : $urandom_range(2, n + 4);
    mn = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, n + 4);
    set_regs(bw, bd, mx, mn);
  endtask

  int unsigned sent;
  int unsigned fsize;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // all costs infinite, then extremes and ties at reset settings
    send_token(COST_INF, 24'hFFFFFF, 1);
    send_token(COST_INF, 24'h000001, 0);
    send_token(COST_INF, 24'h000002, 1);
    send_token(32'sh8000_0000, 24'hFFFFFF, 0);
    send_token(32'sh8000_0000, 24'h000000, 0);
    send_token(COST_INF, 24'h555555, 1);
    // a cap of two decides
    set_regs(24'hFFFFFF, 0, 2, 0);
    send_token(100, 24'hAAAAAA, 0);
    send_token(50, 24'h123456, 0);
    send_token(50, 24'h654321, 0);
    send_token(300, 24'h000010, 0);
    send_token(400, 24'h000011, 1);
    // floor rank decides, with the floor below and then above the cap
    set_regs(0, 24'hFFFFFF, 6, 4);
    for (int i = 0; i < 5; i++) send_token(i * 1000, 24'(i), i == 4);
    set_regs(10, 7, 3, 5);
    for (int i = 0; i < 7; i++) send_token(i * 500, 24'(i + 9), i == 6);
    // store full: extra tokens get dropped
    set_regs(4096, 128, 1024, 0);
    for (int i = 0; i < 1030; i++)
      send_token($signed($urandom_range(0, 4000)) - 2000,
                 24'($urandom_range(0, 24'hFFFFFF)), i == 1029);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 54 : 0;
      rx_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 34 : 0;
      sent = 0;
      if (ph == 2) begin
        // long hold-off while frames keep coming, so the input stalls
        hold_req = 1;
        for (int f = 0; f < 3; f++) random_frame(8);
        sent = 24;
      end
      while (sent < 215) begin
        fsize = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 80)
                                              : $urandom_range(1, 24);
        if ($urandom_range(0, 2) == 0) random_regs(fsize);
        random_frame(fsize);
        sent += fsize;
      end
    end
    set_regs(4096, 128, 1024, 20);

    wait_idle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
